// ===== hdl/mcc_pkg.sv =====
// Shared types, constants and the month length table of the minute calendar clock.
`default_nettype none

package mcc_pkg;

	// Command codes carried in the cmd field of a request beat
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SET  = 1'b1
	} cmd_e_t;

	// Time and date as held in the counters and shown on the result channel
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} cal_t;

	localparam logic [5:0] INIT_MINUTE = 6'd0;
	localparam logic [4:0] INIT_HOUR   = 5'd0;
	localparam logic [4:0] INIT_DAY    = 5'd1;
	localparam logic [3:0] INIT_MONTH  = 4'd1;
	localparam logic [6:0] INIT_YEAR   = 7'd0;

	localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
	localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
	localparam logic [4:0] MONTHS_LIMIT     = 5'd13;
	localparam logic [7:0] YEARS_LIMIT      = 8'd100;
	localparam logic [3:0] MONTH_FEB        = 4'd2;
	localparam logic [5:0] LEAP_DAY         = 6'd29;

	// Days in a month; codes outside January to December count as 31 days
	function automatic logic [4:0] month_length(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd2:                    len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mcc_if.sv =====
// Request and result channel interfaces of the minute calendar clock.
`default_nettype none

interface mcc_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [4:0] set_hour;
	logic [5:0] set_minute;
	logic [4:0] set_day;
	logic [3:0] set_month;
	logic [6:0] set_year;

	modport source (
		output valid, cmd, set_hour, set_minute, set_day, set_month, set_year,
		input  ready
	);
	modport sink (
		input  valid, cmd, set_hour, set_minute, set_day, set_month, set_year,
		output ready
	);
endinterface

interface mcc_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [4:0] day;
	logic [3:0] month;
	logic [6:0] year;

	modport source (
		output valid, hour, minute, day, month, year,
		input  ready
	);
	modport sink (
		input  valid, hour, minute, day, month, year,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/minute_calendar_clock.sv =====
// Top level of the minute calendar clock: request register, counters and result channel.
`default_nettype none

// Minute calendar clock. Each request beat is either a one-minute tick or a set
// command that loads hour, minute, day, month and two-digit year as given, even
// out of calendar range. Every beat returns exactly one result beat holding the
// time and date after it. The block takes one beat per cycle while the result
// side keeps accepting: a request lands in a request register, and the cascaded
// minute, hour, day, month and year compares and increments then update the
// counters, which double as the result register. When the result side stalls,
// one more request is still taken into the request register; after that
// req.ready follows rsp.ready. After reset the clock reads 00:00 on day 1 of
// month 1, year 0. February has 28 days plus day 29 in years divisible by four.
module minute_calendar_clock (
	input  wire       clk,
	input  wire       arst_n,
	mcc_req_if.sink   req,
	mcc_rsp_if.source rsp
);
	import mcc_pkg::*;

	logic   valid_s1;
	cmd_e_t cmd_s1;
	cal_t   set_s1;
	cal_t   cal_q;
	cal_t   cal_next;
	logic   rsp_valid_q;
	logic   req_fire;
	logic   step;

	// Advance the counters whenever the held request can hand its result on
	assign step      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || step;
	assign req_fire  = req.valid && req.ready;

	// Hold the accepted request beat; payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1        <= cmd_e_t'(req.cmd);
			set_s1.hour   <= req.set_hour;
			set_s1.minute <= req.set_minute;
			set_s1.day    <= req.set_day;
			set_s1.month  <= req.set_month;
			set_s1.year   <= req.set_year;
		end
	end

	mcc_advance u_advance (
		.cur (cal_q),
		.cmd (cmd_s1),
		.set (set_s1),
		.nxt (cal_next)
	);

	// Counters are the calendar state and the result payload at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.hour   <= INIT_HOUR;
			cal_q.minute <= INIT_MINUTE;
			cal_q.day    <= INIT_DAY;
			cal_q.month  <= INIT_MONTH;
			cal_q.year   <= INIT_YEAR;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (step) begin
				cal_q <= cal_next;
			end
			if (step) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.hour   = cal_q.hour;
	assign rsp.minute = cal_q.minute;
	assign rsp.day    = cal_q.day;
	assign rsp.month  = cal_q.month;
	assign rsp.year   = cal_q.year;

	// A set beat shows its own fields in the result it produces
	a_set_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step && (cmd_s1 == CMD_SET) |=> rsp.valid && (cal_q == $past(set_s1)))
		else $error("set command not loaded into the counters");

	// A tick from an in-range minute below 59 only advances the minute
	a_tick_minute: assert property (@(posedge clk) disable iff (!arst_n)
		step && (cmd_s1 == CMD_TICK) && (cal_q.minute < 6'd59)
		|=> (cal_q.minute == $past(cal_q.minute) + 6'd1)
			&& (cal_q.hour == $past(cal_q.hour)) && (cal_q.day == $past(cal_q.day)))
		else $error("tick did not advance the minute alone");

	// An empty request register always takes a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("request refused with empty request register");

	// Counters move only when a result is produced
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(cal_q))
		else $error("counters changed without a beat");

endmodule

`default_nettype wire

// ===== hdl/mcc_advance.sv =====
// Next time and date from the current one for a tick or a set command.
`default_nettype none

module mcc_advance (
	input  mcc_pkg::cal_t   cur,
	input  mcc_pkg::cmd_e_t cmd,
	input  mcc_pkg::cal_t   set,
	output mcc_pkg::cal_t   nxt
);
	import mcc_pkg::*;

	cal_t       ticked;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [5:0] day_inc;
	logic [4:0] month_inc;
	logic [7:0] year_inc;
	logic       leap_feb;

	assign min_inc   = {1'b0, cur.minute} + 7'd1;
	assign hour_inc  = {1'b0, cur.hour} + 6'd1;
	assign day_inc   = {1'b0, cur.day} + 6'd1;
	assign month_inc = {1'b0, cur.month} + 5'd1;
	assign year_inc  = {1'b0, cur.year} + 8'd1;
	assign leap_feb  = (cur.month == MONTH_FEB) && (cur.year[1:0] == 2'b00)
		&& (day_inc == LEAP_DAY);

	always_comb begin
		ticked = cur;
		if (min_inc < MINUTES_PER_HOUR) begin
			ticked.minute = min_inc[5:0];
		end else begin
			// carry into the hour; an out-of-range minute drops the limit once
			ticked.minute = 6'(min_inc - MINUTES_PER_HOUR);
			if (hour_inc < HOURS_PER_DAY) begin
				ticked.hour = hour_inc[4:0];
			end else begin
				ticked.hour = 5'(hour_inc - HOURS_PER_DAY);
				if ((cur.day < month_length(cur.month)) || leap_feb) begin
					ticked.day = day_inc[4:0];
				end else begin
					ticked.day = 5'd1;
					if (month_inc < MONTHS_LIMIT) begin
						ticked.month = month_inc[3:0];
					end else begin
						ticked.month = 4'd1;
						ticked.year  = (year_inc >= YEARS_LIMIT) ? 7'd0 : year_inc[6:0];
					end
				end
			end
		end
	end

	assign nxt = (cmd == CMD_SET) ? set : ticked;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the minute calendar clock: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb_top;
	import mcc_pkg::*;

	// One request beat as the driver holds it
	typedef struct packed {
		cmd_e_t     cmd;
		logic [4:0] set_hour;
		logic [5:0] set_minute;
		logic [4:0] set_day;
		logic [3:0] set_month;
		logic [6:0] set_year;
	} req_beat_t;

	// Tracks the calendar that the block should show and checks each reading
	// against the oldest one still owed.
	class calendar_checker;
		cal_t        tracked;
		cal_t        pending_dates[$];
		int unsigned errors;
		int unsigned ticks;
		int unsigned sets;
		int unsigned month_carries;
		int unsigned year_wraps;
		int unsigned leap_days;

		function new();
			tracked = '{hour: INIT_HOUR, minute: INIT_MINUTE, day: INIT_DAY,
				month: INIT_MONTH, year: INIT_YEAR};
			errors = 0;
			ticks = 0;
			sets = 0;
			month_carries = 0;
			year_wraps = 0;
			leap_days = 0;
		endfunction

		// Month lengths; codes outside January to December count as 31 days
		static function int unsigned days_of_month(logic [3:0] mo);
			int unsigned len;
			case (mo)
				4'd2:                    len = 28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 30;
				default:                 len = 31;
			endcase
			return len;
		endfunction

		// Advance the tracked calendar by one minute, carrying as far as needed
		function void advance_minute();
			int unsigned m;
			int unsigned h;
			int unsigned d;
			int unsigned mo;
			int unsigned y;
			m = int'(tracked.minute) + 1;
			if (m < MINUTES_PER_HOUR) begin
				tracked.minute = 6'(m);
				return;
			end
			tracked.minute = 6'(m - MINUTES_PER_HOUR);
			h = int'(tracked.hour) + 1;
			if (h < HOURS_PER_DAY) begin
				tracked.hour = 5'(h);
				return;
			end
			tracked.hour = 5'(h - HOURS_PER_DAY);
			d = int'(tracked.day) + 1;
			if ((d - 1) < days_of_month(tracked.month) ||
				(tracked.month == MONTH_FEB && tracked.year[1:0] == 2'b00 &&
				d == LEAP_DAY)) begin
				if (tracked.month == MONTH_FEB && d == LEAP_DAY)
					leap_days++;
				tracked.day = 5'(d);
				return;
			end
			tracked.day = 5'd1;
			month_carries++;
			mo = int'(tracked.month) + 1;
			if (mo < MONTHS_LIMIT) begin
				tracked.month = 4'(mo);
				return;
			end
			tracked.month = 4'd1;
			y = int'(tracked.year) + 1;
			if (y >= YEARS_LIMIT) begin
				tracked.year = 7'd0;
				year_wraps++;
			end else begin
				tracked.year = 7'(y);
			end
		endfunction

		// Apply an accepted request beat and owe one reading for it
		function void note_request(req_beat_t b);
			if (b.cmd == CMD_SET) begin
				tracked.hour   = b.set_hour;
				tracked.minute = b.set_minute;
				tracked.day    = b.set_day;
				tracked.month  = b.set_month;
				tracked.year   = b.set_year;
				sets++;
			end else begin
				advance_minute();
				ticks++;
			end
			pending_dates.push_back(tracked);
		endfunction

		function void compare_field(string name, logic [6:0] want, logic [6:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted result beat with the oldest owed reading
		function void check_reading(cal_t got);
			cal_t want;
			if (pending_dates.size() == 0) begin
				$display("%0t: unexpected reading, expected none, got %0d:%0d %0d/%0d/%0d",
					$time, got.hour, got.minute, got.day, got.month, got.year);
				errors++;
				return;
			end
			want = pending_dates.pop_front();
			compare_field("hour",   7'(want.hour),   7'(got.hour));
			compare_field("minute", 7'(want.minute), 7'(got.minute));
			compare_field("day",    7'(want.day),    7'(got.day));
			compare_field("month",  7'(want.month),  7'(got.month));
			compare_field("year",   want.year,       got.year);
		endfunction
	endclass

	localparam int RANDOM_BEATS = 1825;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mcc_req_if req_if();
	mcc_rsp_if rsp_if();

	minute_calendar_clock u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	calendar_checker chk = new();

	int unsigned sent     = 0;
	int unsigned received = 0;
	bit          calm_req = 1'b0;
	bit          calm_rsp = 1'b0;

	always #1 clk = ~clk;

	// Drive every input to a known level from time zero
	initial begin
		req_if.valid      = 1'b0;
		req_if.cmd        = CMD_TICK;
		req_if.set_hour   = '0;
		req_if.set_minute = '0;
		req_if.set_day    = '0;
		req_if.set_month  = '0;
		req_if.set_year   = '0;
		rsp_if.ready      = 1'b0;
	end

	function automatic req_beat_t set_beat(int h, int m, int d, int mo, int y);
		req_beat_t b;
		b.cmd        = CMD_SET;
		b.set_hour   = 5'(h);
		b.set_minute = 6'(m);
		b.set_day    = 5'(d);
		b.set_month  = 4'(mo);
		b.set_year   = 7'(y);
		return b;
	endfunction

	// A tick carries random set fields, which the block must ignore
	function automatic req_beat_t tick_beat();
		req_beat_t b;
		b = set_beat($urandom, $urandom, $urandom, $urandom, $urandom);
		b.cmd = CMD_TICK;
		return b;
	endfunction

	// A legal setting a few minutes short of an hour carry, often also of a day, month or year carry
	function automatic req_beat_t near_rollover_set();
		int y;
		int mo;
		int len;
		int h;
		y   = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
		mo  = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
		len = calendar_checker::days_of_month(4'(mo));
		if (mo == 2 && y % 4 == 0)
			len = 29;
		h   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23;
		return set_beat(h, $urandom_range(50, 59), $urandom_range(len - 1, len), mo, y);
	endfunction

	// Offer one request beat; entered and left at a falling edge
	task automatic send_beat(input req_beat_t b);
		int gap;
		gap = calm_req ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.cmd        = b.cmd;
		req_if.set_hour   = b.set_hour;
		req_if.set_minute = b.set_minute;
		req_if.set_day    = b.set_day;
		req_if.set_month  = b.set_month;
		req_if.set_year   = b.set_year;
		req_if.valid      = 1'b1;
		// Hold the beat until the block takes it
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		chk.note_request(b);
		sent++;
		// Switch between idling and back-to-back stretches now and then
		if (sent % 64 == 0)
			calm_req = ($urandom_range(0, 3) == 0);
		@(negedge clk);
	endtask

	// Result side: stall at random, then take and check each result beat
	initial begin
		int   gap;
		cal_t got;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = calm_rsp ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				rsp_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			@(posedge clk);
			while (rsp_if.valid !== 1'b1)
				@(posedge clk);
			got = {rsp_if.hour, rsp_if.minute, rsp_if.day, rsp_if.month, rsp_if.year};
			chk.check_reading(got);
			received++;
			if (received % 64 == 0)
				calm_rsp = ($urandom_range(0, 3) == 0);
			@(negedge clk);
		end
	end

	// Main sequence: reset, directed beats, random beats, drain and report
	initial begin
		int        spins;
		int        pick;
		req_beat_t b;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: first tick out of reset, field extremes and each
		// awkward corner of the carry chain
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 31, 12, 99));   // new year's eve, year wraps to 0
		send_beat(tick_beat());
		send_beat(set_beat(31, 63, 31, 15, 127));  // every set bit high
		send_beat(tick_beat());                    // minute and hour above range
		send_beat(set_beat(0, 0, 0, 0, 0));        // every set bit low
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 28, 2, 4));     // leap year, reach day 29
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 29, 2, 4));     // leave the leap day
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 28, 2, 1));     // common year, skip day 29
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 30, 4, 10));    // end of a 30-day month
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 31, 0, 50));    // month code 0 counts 31 days
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 31, 15, 127));  // month 15 and year 127 carry
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 0, 5, 7));      // day 0 steps to day 1
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 30, 2, 8));     // day past February in leap year
		send_beat(tick_beat());
		send_beat(set_beat(23, 59, 31, 4, 3));     // day 31 in a 30-day month
		send_beat(tick_beat());

		// Random part: mostly ticks, with settings placed just short of a carry
		// so that runs of ticks cross days, months and years; a few settings
		// take any value at full width
		repeat (RANDOM_BEATS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				b = near_rollover_set();
			else if (pick < 9)
				b = set_beat($urandom, $urandom, $urandom, $urandom, $urandom);
			else
				b = tick_beat();
			send_beat(b);
		end
		req_if.valid = 1'b0;

		// Drain: wait for every owed reading, then keep watching for strays before the report
		spins = 0;
		while (chk.pending_dates.size() != 0 && spins < 2000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);
		if (chk.pending_dates.size() != 0) begin
			$display("%0t: %0d readings expected, none arrived",
				$time, chk.pending_dates.size());
			chk.errors++;
		end

		$display("Sent %0d request beats (%0d ticks, %0d settings), checked %0d readings.",
			sent, chk.ticks, chk.sets, received);
		$display("Crossed %0d month ends and %0d year wraps, reached %0d leap days.",
			chk.month_carries, chk.year_wraps, chk.leap_days);
		if (chk.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Give up if the handshakes stop moving
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== minute_calendar_clock.f =====
hdl/mcc_pkg.sv
hdl/mcc_if.sv
hdl/mcc_advance.sv
hdl/minute_calendar_clock.sv
tb/sv/tb_top.sv
